### rtl/multi_click_button_detector_top_defines.svh
// Assertion helpers for the button detector.
// Both forms sample on clk and are disabled while rst is high.
`ifndef MULTI_CLICK_BUTTON_DETECTOR_TOP_DEFINES_SVH
`define MULTI_CLICK_BUTTON_DETECTOR_TOP_DEFINES_SVH
`ifndef SYNTH
`define MCB_ASSERT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("button detector check failed");
`define MCB_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("button detector check failed");
`else
`define MCB_ASSERT(name, ante, cons)
`define MCB_ASSERT_NEXT(name, ante, cons)
`endif
`endif

### rtl/mcb_pkg.sv
package mcb_pkg;

  localparam int BUTTONS    = 2;
  localparam int MAX_HITS   = 6;
  localparam int TIME_BITS  = 16;
  localparam int CODE_W     = 3;
  localparam int BTN_W      = 1;
  localparam int CFG_W      = 16;
  localparam int CFG_IDX_W  = 8;
  localparam int IN_DATA_W  = 8;
  localparam int OUT_DATA_W = 8;
  localparam int CMP_W      = (TIME_BITS > CFG_W) ? TIME_BITS : CFG_W;

  typedef logic [TIME_BITS-1:0] time_t;
  typedef logic [CODE_W-1:0]    code_t;
  typedef logic [BTN_W-1:0]     btn_t;
  typedef logic [CFG_W-1:0]     cfg_word_t;

  localparam code_t CODE_NONE = '0;
  localparam code_t CODE_LONG = CODE_W'(MAX_HITS + 1);
  localparam code_t CODE_SAT  = CODE_W'(MAX_HITS);
  localparam btn_t  BTN_LAST  = BTN_W'(BUTTONS - 1);

  localparam logic CMD_TICK = 1'b0;
  localparam logic CMD_READ = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_CONFIRM = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_SHORT   = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_LONG    = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_GAP     = CFG_IDX_W'(3);

  typedef enum logic [2:0] {
    PH_RELEASE,
    PH_CONFIRM,
    PH_SHORT,
    PH_LONG,
    PH_WAIT
  } phase_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FLUSH,
    ST_RESULT
  } seq_state_t;

  typedef struct packed {
    phase_t phase;
    time_t  last_change;
    code_t  pend_code;
    code_t  fin_code;
  } entry_t;

  localparam entry_t ENTRY_RESET = '{
    phase:       PH_RELEASE,
    last_change: '0,
    pend_code:   CODE_NONE,
    fin_code:    CODE_NONE
  };

  typedef struct packed {
    cfg_word_t confirm_ticks;
    cfg_word_t short_ticks;
    cfg_word_t long_ticks;
    cfg_word_t gap_ticks;
  } cfg_t;

  typedef struct packed {
    logic   rd_en;
    btn_t   rd_addr;
    logic   wr_en;
    btn_t   wr_addr;
    entry_t wr_data;
  } mem_req_t;

endpackage

### rtl/mcb_cfg_regs.sv
module mcb_cfg_regs (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             wr_en,
  input  logic [mcb_pkg::CFG_IDX_W-1:0]    wr_index,
  input  logic [mcb_pkg::CFG_W-1:0]        wr_data,
  output mcb_pkg::cfg_t                    cfg
);
  import mcb_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.confirm_ticks <= CFG_W'(20);
      cfg.short_ticks   <= CFG_W'(50);
      cfg.long_ticks    <= CFG_W'(100);
      cfg.gap_ticks     <= CFG_W'(30);
    end else if (wr_en) begin
      case (wr_index)
        REG_CONFIRM: cfg.confirm_ticks <= wr_data;
        REG_SHORT:   cfg.short_ticks   <= wr_data;
        REG_LONG:    cfg.long_ticks    <= wr_data;
        REG_GAP:     cfg.gap_ticks     <= wr_data;
        default: begin
        end
      endcase
    end
  end

endmodule

### rtl/mcb_state_mem.sv
module mcb_state_mem (
  input  logic              clk,
  input  logic              rst,
  input  mcb_pkg::mem_req_t req,
  output mcb_pkg::entry_t   rd_data
);
  import mcb_pkg::*;

  entry_t             mem [BUTTONS];
  logic [BUTTONS-1:0] valid;
  entry_t             rd_raw;
  logic               rd_valid;

  // An entry never written since reset reads as its reset value.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= '0;
      rd_valid <= 1'b0;
    end else begin
      if (req.wr_en) begin
        valid[req.wr_addr] <= 1'b1;
      end
      if (req.rd_en) begin
        rd_valid <= valid[req.rd_addr];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_raw <= mem[req.rd_addr];
    end
  end

  assign rd_data = rd_valid ? rd_raw : ENTRY_RESET;

endmodule

### rtl/mcb_button_step.sv
module mcb_button_step (
  input  mcb_pkg::entry_t cur,
  input  logic            down,
  input  mcb_pkg::time_t  time_now,
  input  mcb_pkg::cfg_t   cfg,
  output mcb_pkg::entry_t nxt
);
  import mcb_pkg::*;

  time_t            elapsed;
  logic [CMP_W-1:0] el_cmp;
  logic             over_confirm;
  logic             over_short;
  logic             over_long;
  logic             over_gap;

  assign elapsed      = time_now - cur.last_change;
  assign el_cmp       = CMP_W'(elapsed);
  assign over_confirm = el_cmp > CMP_W'(cfg.confirm_ticks);
  assign over_short   = el_cmp > CMP_W'(cfg.short_ticks);
  assign over_long    = el_cmp > CMP_W'(cfg.long_ticks);
  assign over_gap     = el_cmp > CMP_W'(cfg.gap_ticks);

  always_comb begin
    nxt = cur;
    case (cur.phase)
      PH_RELEASE: begin
        nxt.pend_code = CODE_NONE;
        if (down && over_confirm) begin
          nxt.phase       = PH_CONFIRM;
          nxt.last_change = time_now;
        end
      end
      PH_CONFIRM: begin
        if (!down) begin
          nxt.phase       = PH_RELEASE;
          nxt.last_change = time_now;
        end else if (over_short) begin
          nxt.phase       = PH_SHORT;
          nxt.last_change = time_now;
        end
      end
      PH_SHORT: begin
        if (!down) begin
          if (cur.pend_code < CODE_SAT) begin
            nxt.pend_code = cur.pend_code + CODE_W'(1);
          end
          nxt.phase       = PH_WAIT;
          nxt.last_change = time_now;
        end else if (over_long) begin
          nxt.pend_code   = CODE_LONG;
          nxt.phase       = PH_LONG;
          nxt.last_change = time_now;
        end
      end
      PH_LONG: begin
        nxt.last_change = time_now;
        if (!down) begin
          nxt.fin_code = cur.pend_code;
          nxt.phase    = PH_RELEASE;
        end
      end
      PH_WAIT: begin
        if (!down) begin
          if (over_gap) begin
            nxt.fin_code    = cur.pend_code;
            nxt.phase       = PH_RELEASE;
            nxt.last_change = time_now;
          end
        end else if (over_confirm) begin
          nxt.phase       = PH_CONFIRM;
          nxt.last_change = time_now;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

### rtl/multi_click_button_detector_top.sv
// Channel   Direction  Fields
// s_axis    in         tuser: cmd; tdata: pressed_bits, button_index
// m_axis    out        tdata: hit_code
// cfg       in         cfg_index, cfg_data (register write)
//
// A tick item first takes the transfer, then reads each button in turn through the single
// read port of the state memory, and ends with the write-back of the last button. A read
// item does the memory read, then the result load.
// A read result waits in its state while the output register is still full.
// Reset is synchronous and needs no clearing pass; per-entry valid bits stand in for it.
// Configuration writes are taken in any cycle.
`include "multi_click_button_detector_top_defines.svh"

module multi_click_button_detector_top (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // tdata: [1:0] pressed_bits, [2] button_index, [7:3] zero
  input  logic [mcb_pkg::IN_DATA_W-1:0]       s_axis_tdata,
  // tuser: [0] cmd
  input  logic                                s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // tdata: [2:0] hit_code, [7:3] zero
  output logic [mcb_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [mcb_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [mcb_pkg::CFG_W-1:0]           cfg_data
);
  import mcb_pkg::*;

  // Input fields as they come off the slave-side bus.
  logic               in_cmd;
  logic [BUTTONS-1:0] in_pressed;
  btn_t               in_idx;
  logic               in_accept;

  assign in_cmd     = s_axis_tuser;
  assign in_pressed = s_axis_tdata[BUTTONS-1:0];
  assign in_idx     = s_axis_tdata[BUTTONS +: BTN_W];
  assign in_accept  = s_axis_tvalid && s_axis_tready;

  // The configuration port never stalls.
  cfg_t cfg;
  assign cfg_ready = 1'b1;

  mcb_cfg_regs u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  // Sequencer state.
  seq_state_t         state;
  seq_state_t         state_next;
  btn_t               btn;
  time_t              time_now;
  logic [BUTTONS-1:0] pressed_q;
  logic               wb_valid;
  btn_t               wb_btn;
  btn_t               rd_btn_q;
  logic               in_range_q;
  logic               out_valid;
  logic               out_valid_next;
  code_t              out_code;
  logic               out_free;
  logic               out_load;

  mem_req_t mem_req;
  entry_t   rd_data;
  entry_t   step_next;

  mcb_state_mem u_mem (
    .clk     (clk),
    .rst     (rst),
    .req     (mem_req),
    .rd_data (rd_data)
  );

  // The entry read in the previous scan cycle is stepped here and written back.
  mcb_button_step u_step (
    .cur      (rd_data),
    .down     (pressed_q[wb_btn]),
    .time_now (time_now),
    .cfg      (cfg),
    .nxt      (step_next)
  );

  assign out_free = !out_valid || m_axis_tready;

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_accept) begin
          state_next = (in_cmd == CMD_TICK) ? ST_SCAN : ST_RESULT;
        end
      end
      ST_SCAN: begin
        if (btn == BTN_LAST) begin
          state_next = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        state_next = ST_IDLE;
      end
      ST_RESULT: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Memory requests, intake and result load.
  always_comb begin
    s_axis_tready = (state == ST_IDLE);
    out_load      = 1'b0;
    mem_req       = '0;
    case (state)
      ST_IDLE: begin
        // A read item fetches its entry in the cycle of the transfer.
        mem_req.rd_en   = in_accept && (in_cmd == CMD_READ);
        mem_req.rd_addr = in_idx;
      end
      ST_SCAN: begin
        mem_req.rd_en   = 1'b1;
        mem_req.rd_addr = btn;
      end
      ST_RESULT: begin
        out_load                 = out_free;
        mem_req.wr_en            = out_free && in_range_q;
        mem_req.wr_addr          = rd_btn_q;
        mem_req.wr_data          = rd_data;
        mem_req.wr_data.fin_code = CODE_NONE;
      end
      default: begin
      end
    endcase
    // Write-back of a stepped button, in the cycle after its read.
    if (wb_valid) begin
      mem_req.wr_en   = 1'b1;
      mem_req.wr_addr = wb_btn;
      mem_req.wr_data = step_next;
    end
  end

  assign out_valid_next = out_load || (out_valid && !m_axis_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      btn       <= '0;
      time_now  <= '0;
      wb_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      wb_valid  <= (state == ST_SCAN);
      out_valid <= out_valid_next;
      if (in_accept) begin
        btn <= '0;
        if (in_cmd == CMD_TICK) begin
          time_now <= time_now + TIME_BITS'(1);
        end
      end else if (state == ST_SCAN) begin
        btn <= btn + BTN_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      pressed_q  <= in_pressed;
      rd_btn_q   <= in_idx;
      in_range_q <= int'(in_idx) < BUTTONS;
    end
    wb_btn <= btn;
    if (out_load) begin
      out_code <= in_range_q ? rd_data.fin_code : CODE_NONE;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {{(OUT_DATA_W - CODE_W){1'b0}}, out_code};

  // A read and a write in one cycle always go to different buttons.
  `MCB_ASSERT(a_no_entry_clash, mem_req.rd_en && mem_req.wr_en, mem_req.rd_addr != mem_req.wr_addr)
  // No new item is taken while a write-back is still due.
  `MCB_ASSERT(a_intake_after_wb, s_axis_tready, !wb_valid)
  // A tick advances the time counter by exactly one.
  `MCB_ASSERT_NEXT(a_tick_time, in_accept && (in_cmd == CMD_TICK), time_now == $past(time_now) + TIME_BITS'(1))
  // A read result is offered as soon as the output register is free.
  `MCB_ASSERT_NEXT(a_result_shown, (state == ST_RESULT) && out_free, m_axis_tvalid)

endmodule

### tb/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import mcb_pkg::*;

  // Cycles with no transfer on any channel before the run is declared hung.
  localparam int WATCHDOG_LIMIT = 2000;
  // Quiet cycles after the last result. A tick keeps the block busy through
  // its scan and write-back without producing anything, so this is ample.
  localparam int DRAIN_CYCLES = 16;
  // Mix of the random part, in percent of items.
  localparam int READ_PCT  = 20;
  localparam int NOISE_PCT = 8;
  // Hold times are derived from the thresholds, but never longer than this,
  // so that the extreme settings do not stretch the run.
  localparam int unsigned RUN_CAP = 120;
  // A register index past the end of the list; the block must ignore it.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = '1;

  // One stream item as the sender sees it.
  typedef struct packed {
    logic               cmd;
    logic [BUTTONS-1:0] pressed;
    btn_t               btn;
  } button_item_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_DATA_W-1:0]   s_axis_tdata = '0;
  logic                   s_axis_tuser = CMD_TICK;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0]  m_axis_tdata;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  cfg_word_t              cfg_data = '0;

  multi_click_button_detector_top dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Items waiting to be offered on the input stream, and the hit codes that
  // accepted read items still owe us, oldest first.
  button_item_t pending_items[$];
  code_t        owed_codes[$];

  // Our own copy of the detector: thresholds, the tick counter and the
  // per-button gesture machines. Values match the block after reset.
  cfg_word_t thr_confirm = 16'd20;
  cfg_word_t thr_short   = 16'd50;
  cfg_word_t thr_long    = 16'd100;
  cfg_word_t thr_gap     = 16'd30;
  time_t     tick_count  = '0;
  phase_t    btn_phase   [BUTTONS] = '{default: PH_RELEASE};
  time_t     btn_mark    [BUTTONS] = '{default: '0};
  code_t     btn_pending [BUTTONS] = '{default: CODE_NONE};
  code_t     btn_latched [BUTTONS] = '{default: CODE_NONE};

  // State of the gesture generator: the level each button is held at and
  // how many more ticks it stays there.
  logic        run_level [BUTTONS] = '{default: 1'b0};
  int unsigned run_left  [BUTTONS] = '{default: 0};

  int unsigned sender_idle_pct   = 0;
  int unsigned receiver_idle_pct = 0;
  int unsigned items_queued      = 0;
  int unsigned items_accepted    = 0;
  int unsigned ticks_applied     = 0;
  int unsigned reads_applied     = 0;
  int unsigned click_codes_seen  = 0;
  int unsigned long_codes_seen   = 0;
  int unsigned settings_used     = 1;
  int unsigned reg_writes        = 0;
  int unsigned error_count       = 0;
  int unsigned quiet_cycles      = 0;
  button_item_t next_item;
  code_t        want_code;

  // Record a change of phase: the time since the last change restarts here.
  function automatic void move_to(int b, phase_t next);
    btn_mark[b]  = tick_count;
    btn_phase[b] = next;
  endfunction

  // One tick: advance time, then step every button's machine with its level.
  // All thresholds are strict, and elapsed time wraps with the counter.
  function automatic void advance_buttons(logic [BUTTONS-1:0] levels);
    time_t held;
    logic  down;
    tick_count = tick_count + TIME_BITS'(1);
    for (int b = 0; b < BUTTONS; b++) begin
      down = levels[b];
      held = tick_count - btn_mark[b];
      case (btn_phase[b])
        PH_RELEASE: begin
          btn_pending[b] = CODE_NONE;
          if (down && held > thr_confirm) move_to(b, PH_CONFIRM);
        end
        PH_CONFIRM: begin
          // Letting go before the short threshold drops the whole gesture.
          if (!down) move_to(b, PH_RELEASE);
          else if (held > thr_short) move_to(b, PH_SHORT);
        end
        PH_SHORT: begin
          if (down && held > thr_long) begin
            btn_pending[b] = CODE_LONG;
            move_to(b, PH_LONG);
          end else if (!down) begin
            if (btn_pending[b] < CODE_SAT) btn_pending[b] = btn_pending[b] + CODE_W'(1);
            move_to(b, PH_WAIT);
          end
        end
        PH_LONG: begin
          // The mark follows every tick while held; release latches the code.
          if (!down) btn_latched[b] = btn_pending[b];
          move_to(b, down ? PH_LONG : PH_RELEASE);
        end
        PH_WAIT: begin
          if (!down && held > thr_gap) begin
            btn_latched[b] = btn_pending[b];
            move_to(b, PH_RELEASE);
          end else if (down && held > thr_confirm) begin
            move_to(b, PH_CONFIRM);
          end
        end
        default: ;
      endcase
    end
  endfunction

  function automatic int unsigned capped(cfg_word_t value);
    return (value > RUN_CAP) ? RUN_CAP : int'(value);
  endfunction

  // Input side: take note of each accepted transfer and work out what it
  // owes, then decide what to offer next. A new item is only put up once the
  // previous one has been taken, and tvalid gets one assignment per edge.
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      s_axis_tuser  <= CMD_TICK;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        if (s_axis_tuser == CMD_TICK) begin
          advance_buttons(s_axis_tdata[BUTTONS-1:0]);
          ticks_applied++;
        end else begin
          // A read hands back the latched code of one button and clears it;
          // the machines themselves are left alone.
          owed_codes.push_back(btn_latched[s_axis_tdata[BUTTONS +: BTN_W]]);
          btn_latched[s_axis_tdata[BUTTONS +: BTN_W]] = CODE_NONE;
          reads_applied++;
        end
        items_accepted++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (pending_items.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
          next_item = pending_items.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tuser  <= next_item.cmd;
          s_axis_tdata  <= IN_DATA_W'({next_item.btn, next_item.pressed});
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Output side: every result transfer must match the oldest owed code, and
  // the padding above the code must be zero. Ready is stalled at random.
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (owed_codes.size() == 0) begin
          $display("%0t: result with none owed, expected nothing, got tdata 0x%h",
                   $time, m_axis_tdata);
          error_count++;
        end else begin
          want_code = owed_codes.pop_front();
          if (m_axis_tdata !== OUT_DATA_W'(want_code)) begin
            $display("%0t: hit code mismatch, expected %0d, got %0d (tdata 0x%h)",
                     $time, want_code, m_axis_tdata[CODE_W-1:0], m_axis_tdata);
            error_count++;
          end
          if (want_code == CODE_LONG) long_codes_seen++;
          else if (want_code != CODE_NONE) click_codes_seen++;
        end
      end
      m_axis_tready <= ($urandom_range(99) >= receiver_idle_pct);
    end
  end

  // Watchdog: any transfer on any channel counts as progress.
  always @(posedge clk) begin
    if (!rst) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid && cfg_ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("testbench failed");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  task automatic push_item(logic cmd, logic [BUTTONS-1:0] pressed, btn_t btn);
    pending_items.push_back('{cmd: cmd, pressed: pressed, btn: btn});
    items_queued++;
  endtask

  // Random stimulus built from gestures. Each button alternates between held
  // and released runs whose lengths are picked around the current thresholds:
  // glitches shorter than the confirm time, clean short clicks, long presses,
  // releases inside the gap (so clicks chain and saturate) and ones past it.
  // Reads and ticks with random pin levels are mixed in.
  task automatic queue_gestures(int unsigned count);
    int unsigned c, s, l, g, pick, roll;
    logic [BUTTONS-1:0] levels;
    c = capped(thr_confirm);
    s = capped(thr_short);
    l = capped(thr_long);
    g = capped(thr_gap);
    repeat (count) begin
      pick = $urandom_range(99);
      if (pick < READ_PCT) begin
        push_item(CMD_READ, BUTTONS'($urandom), BTN_W'($urandom));
      end else if (pick < READ_PCT + NOISE_PCT) begin
        push_item(CMD_TICK, BUTTONS'($urandom), BTN_W'($urandom));
      end else begin
        for (int b = 0; b < BUTTONS; b++) begin
          if (run_left[b] == 0) begin
            run_level[b] = !run_level[b];
            roll = $urandom_range(99);
            if (run_level[b]) begin
              if (roll < 20) run_left[b] = $urandom_range(c + 1, 1);
              else if (roll < 80) run_left[b] = $urandom_range(c + s + l + 1, c + s + 2);
              else run_left[b] = $urandom_range(c + s + l + 5, c + s + l + 2);
            end else begin
              if (roll < 65) run_left[b] = $urandom_range(g + 1, 1);
              else run_left[b] = $urandom_range(g + 6, g + 2);
            end
          end
          levels[b] = run_level[b];
          run_left[b]--;
        end
        push_item(CMD_TICK, levels, BTN_W'($urandom));
      end
    end
  endtask

  // Write one register and mirror it once the transfer has happened. Valid is
  // left high so that back-to-back writes need no second assignment per edge.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, cfg_word_t value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_CONFIRM: thr_confirm = value;
      REG_SHORT:   thr_short   = value;
      REG_LONG:    thr_long    = value;
      REG_GAP:     thr_gap     = value;
      default: ;
    endcase
    reg_writes++;
  endtask

  task automatic load_thresholds(cfg_word_t c, cfg_word_t s, cfg_word_t l, cfg_word_t g);
    write_reg(REG_CONFIRM, c);
    write_reg(REG_SHORT, s);
    write_reg(REG_LONG, l);
    write_reg(REG_GAP, g);
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  // Wait until every queued item has been taken and every owed code has come
  // back, then give the block time to finish a trailing tick.
  task automatic wait_until_quiet();
    while (items_accepted != items_queued || owed_codes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Busy sender, slow receiver. Start on the thresholds the block wakes up
    // with, so the reset values are exercised before anything is written.
    sender_idle_pct   = 24;
    receiver_idle_pct = 82;
    queue_gestures(200);
    wait_until_quiet();

    // A write to an index past the list must change nothing; then zero all
    // thresholds so that every transition fires after a single tick.
    write_reg(REG_SPARE, '1);
    load_thresholds(16'd0, 16'd0, 16'd0, 16'd0);

    // Directed part: reads of whatever the random part left latched, a press
    // released while still being confirmed (both buttons, gesture dropped), a
    // double click on button 0, a long press on button 1, and reads that must
    // find the codes cleared again. Ignored fields carry nonzero values.
    push_item(CMD_READ, 2'b11, 1'b0);
    push_item(CMD_READ, 2'b11, 1'b1);
    push_item(CMD_TICK, 2'b11, 1'b1);
    push_item(CMD_TICK, 2'b00, 1'b1);
    push_item(CMD_TICK, 2'b01, 1'b0);
    push_item(CMD_TICK, 2'b01, 1'b1);
    push_item(CMD_TICK, 2'b00, 1'b0);
    push_item(CMD_TICK, 2'b01, 1'b1);
    push_item(CMD_TICK, 2'b01, 1'b0);
    push_item(CMD_TICK, 2'b00, 1'b1);
    push_item(CMD_TICK, 2'b00, 1'b0);
    push_item(CMD_READ, 2'b10, 1'b0);
    push_item(CMD_TICK, 2'b10, 1'b0);
    push_item(CMD_TICK, 2'b10, 1'b1);
    push_item(CMD_TICK, 2'b10, 1'b0);
    push_item(CMD_TICK, 2'b10, 1'b1);
    push_item(CMD_TICK, 2'b00, 1'b0);
    push_item(CMD_READ, 2'b01, 1'b1);
    push_item(CMD_READ, 2'b00, 1'b1);
    push_item(CMD_READ, 2'b11, 1'b0);
    queue_gestures(80);
    wait_until_quiet();

    // Largest thresholds: presses can never be confirmed.
    load_thresholds('1, '1, '1, '1);
    queue_gestures(40);
    wait_until_quiet();

    // Slow sender, busy receiver, with small thresholds that produce many
    // chained clicks, saturated counts and long presses.
    sender_idle_pct   = 82;
    receiver_idle_pct = 24;
    load_thresholds(16'd2, 16'd3, 16'd6, 16'd4);
    queue_gestures(90);
    wait_until_quiet();
    load_thresholds(16'd1, 16'd1, 16'd1, 16'd1);
    queue_gestures(70);
    wait_until_quiet();
    load_thresholds(16'd0, 16'd3, 16'd0, 16'd7);
    queue_gestures(70);
    wait_until_quiet();

    // No idling on either side.
    sender_idle_pct   = 0;
    receiver_idle_pct = 0;
    repeat (2) begin
      load_thresholds(cfg_word_t'($urandom_range(6)), cfg_word_t'($urandom_range(6)),
                      cfg_word_t'($urandom_range(6)), cfg_word_t'($urandom_range(6)));
      queue_gestures(70);
      wait_until_quiet();
    end
    load_thresholds('1, 16'd0, 16'd0, '1);
    queue_gestures(40);
    wait_until_quiet();
    load_thresholds(16'd20, 16'd50, 16'd100, 16'd30);
    queue_gestures(50);
    wait_until_quiet();

    if (owed_codes.size() != 0) begin
      $display("%0t: %0d hit codes never arrived", $time, owed_codes.size());
      error_count++;
    end
    $display("Summary: %0d ticks and %0d reads over %0d threshold settings, %0d register writes.",
             ticks_applied, reads_applied, settings_used, reg_writes);
    $display("Summary: %0d click-count codes and %0d long-press codes read back, %0d errors.",
             click_codes_seen, long_codes_seen, error_count);
    if (error_count == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
